/* rtl/les_pkg.sv */
// ----------------------------------------------------------------------------
// Lorenz Euler step package
// Shared types, constants and fixed-point helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package les_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;
	localparam int PIX_W      = 13;

	typedef enum logic [3:0] {
		OP_NOP         = 4'd0,
		OP_DIFF_YX     = 4'd1,
		OP_MUL_SIGMA   = 4'd2,
		OP_MUL_DT_PROD = 4'd3,
		OP_UPD_X       = 4'd4,
		OP_MUL_X_ACC   = 4'd5,
		OP_SUB_Y       = 4'd6,
		OP_MUL_DT_ACC  = 4'd7,
		OP_UPD_Y       = 4'd8,
		OP_MUL_XY      = 4'd9,
		OP_MUL_BETA    = 4'd10,
		OP_SUB_PROD    = 4'd11,
		OP_UPD_Z       = 4'd12
	} op_t;

	typedef struct packed {
		op_t op;
	} les_cmd_t;

	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v[32] != v[31]) begin
			r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
		logic signed [39:0] s;
		logic signed [31:0] r;
		s = p[63:24];
		if ((s[39:31] != 9'h000) && (s[39:31] != 9'h1ff)) begin
			r = s[39] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/les_ctrl.sv */
// ----------------------------------------------------------------------------
// Lorenz Euler step controller
// Sequences the datapath through the x, y and z updates of one step.
// ----------------------------------------------------------------------------
`default_nettype none

module les_ctrl
	import les_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     tick_valid,
	output logic          tick_stall,
	input  wire logic     tick,
	output logic          res_valid,
	input  wire logic     res_stall,
	output les_cmd_t      cmd
);

	typedef enum logic [14:0] {
		ST_IDLE = 15'b000000000000001,
		ST_X0   = 15'b000000000000010,
		ST_X1   = 15'b000000000000100,
		ST_X2   = 15'b000000000001000,
		ST_X3   = 15'b000000000010000,
		ST_Y1   = 15'b000000000100000,
		ST_Y2   = 15'b000000001000000,
		ST_Y3   = 15'b000000010000000,
		ST_Y4   = 15'b000000100000000,
		ST_Z1   = 15'b000001000000000,
		ST_Z2   = 15'b000010000000000,
		ST_Z3   = 15'b000100000000000,
		ST_Z4   = 15'b001000000000000,
		ST_Z5   = 15'b010000000000000,
		ST_DONE = 15'b100000000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NOP;
		case (state_q)
			ST_IDLE: begin
				if (tick_valid && tick) begin
					state_d = ST_X0;
				end
			end
			ST_X0: begin
				cmd.op  = OP_DIFF_YX;
				state_d = ST_X1;
			end
			ST_X1: begin
				cmd.op  = OP_MUL_SIGMA;
				state_d = ST_X2;
			end
			ST_X2: begin
				cmd.op  = OP_MUL_DT_PROD;
				state_d = ST_X3;
			end
			ST_X3: begin
				cmd.op  = OP_UPD_X;
				state_d = ST_Y1;
			end
			ST_Y1: begin
				cmd.op  = OP_MUL_X_ACC;
				state_d = ST_Y2;
			end
			ST_Y2: begin
				cmd.op  = OP_SUB_Y;
				state_d = ST_Y3;
			end
			ST_Y3: begin
				cmd.op  = OP_MUL_DT_ACC;
				state_d = ST_Y4;
			end
			ST_Y4: begin
				cmd.op  = OP_UPD_Y;
				state_d = ST_Z1;
			end
			ST_Z1: begin
				cmd.op  = OP_MUL_XY;
				state_d = ST_Z2;
			end
			ST_Z2: begin
				cmd.op  = OP_MUL_BETA;
				state_d = ST_Z3;
			end
			ST_Z3: begin
				cmd.op  = OP_SUB_PROD;
				state_d = ST_Z4;
			end
			ST_Z4: begin
				cmd.op  = OP_MUL_DT_ACC;
				state_d = ST_Z5;
			end
			ST_Z5: begin
				cmd.op  = OP_UPD_Z;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!res_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign tick_stall = (state_q != ST_IDLE);
	assign res_valid  = (state_q == ST_DONE);

endmodule

`default_nettype wire

/* rtl/les_dp.sv */
// ----------------------------------------------------------------------------
// Lorenz Euler step datapath
// Configuration registers, state, one shared multiplier and the pixel mapping.
// ----------------------------------------------------------------------------
`default_nettype none

module les_dp
	import les_pkg::*;
#(
	parameter int FRAME_WIDTH  = 1000,
	parameter int FRAME_HEIGHT = 800
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_write,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data,
	input  wire les_cmd_t                cmd,
	output logic signed [31:0]           x_value,
	output logic signed [31:0]           y_value,
	output logic signed [31:0]           z_value,
	output logic signed [PIX_W-1:0]      pixel_column,
	output logic signed [PIX_W-1:0]      pixel_row,
	output logic                         in_frame
);

	localparam logic [CFG_IDX_W-1:0] CFG_SIGMA = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RHO   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DT    = 3'd3;

	logic [30:0]        sigma_q;
	logic [30:0]        rho_q;
	logic [30:0]        beta_q;
	logic [24:0]        dt_q;
	logic signed [31:0] x_q;
	logic signed [31:0] y_q;
	logic signed [31:0] z_q;
	logic signed [31:0] acc_q;
	logic signed [63:0] prod_q;
	logic signed [PIX_W-1:0] col_q;
	logic signed [PIX_W-1:0] row_q;
	logic               in_frame_q;

	logic signed [31:0] qprod;
	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [63:0] mul_p;
	logic signed [31:0] x_new;
	logic signed [31:0] y_new;
	logic signed [31:0] z_new;
	logic signed [31:0] diff_yx;
	logic signed [31:0] diff_rz;
	logic signed [31:0] diff_py;
	logic signed [31:0] diff_ap;
	logic signed [37:0] col_full;
	logic signed [37:0] row_full;
	logic signed [37:0] col_trunc;
	logic signed [37:0] row_trunc;
	logic signed [13:0] col_int;
	logic signed [13:0] row_int;
	logic               col_ok;
	logic               row_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q <= 31'd167772160;
			rho_q   <= 31'd469762048;
			beta_q  <= 31'd44739243;
			dt_q    <= 25'd1678;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_SIGMA: sigma_q <= cfg_data;
				CFG_RHO:   rho_q   <= cfg_data;
				CFG_BETA:  beta_q  <= cfg_data;
				CFG_DT:    dt_q    <= cfg_data[24:0];
				default: begin
				end
			endcase
		end
	end

	assign qprod   = qsat(prod_q);
	assign diff_yx = sat33({y_q[31], y_q} - {x_q[31], x_q});
	assign diff_rz = sat33({2'b00, rho_q} - {z_q[31], z_q});
	assign diff_py = sat33({qprod[31], qprod} - {y_q[31], y_q});
	assign diff_ap = sat33({acc_q[31], acc_q} - {qprod[31], qprod});
	assign x_new   = sat33({x_q[31], x_q} + {qprod[31], qprod});
	assign y_new   = sat33({y_q[31], y_q} + {qprod[31], qprod});
	assign z_new   = sat33({z_q[31], z_q} + {qprod[31], qprod});

	always_comb begin
		mul_a = acc_q;
		mul_b = {7'd0, dt_q};
		case (cmd.op)
			OP_MUL_SIGMA: begin
				mul_a = {1'b0, sigma_q};
				mul_b = acc_q;
			end
			OP_MUL_DT_PROD: begin
				mul_a = qprod;
				mul_b = {7'd0, dt_q};
			end
			OP_MUL_X_ACC: begin
				mul_a = x_q;
				mul_b = acc_q;
			end
			OP_MUL_DT_ACC: begin
				mul_a = acc_q;
				mul_b = {7'd0, dt_q};
			end
			OP_MUL_XY: begin
				mul_a = x_q;
				mul_b = y_q;
			end
			OP_MUL_BETA: begin
				mul_a = {1'b0, beta_q};
				mul_b = z_q;
			end
			default: begin
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Pixel mapping works from the final x and y, with truncation toward zero.
	assign col_full  = (38'sd500 <<< 24) + ({{6{x_q[31]}}, x_q} <<< 4)
		+ ({{6{x_q[31]}}, x_q} <<< 2);
	assign row_full  = (38'sd400 <<< 24) + ({{6{y_q[31]}}, y_q} <<< 4)
		- ({{6{y_q[31]}}, y_q} <<< 1);
	assign col_trunc = col_full[37] ? col_full + 38'sd16777215 : col_full;
	assign row_trunc = row_full[37] ? row_full + 38'sd16777215 : row_full;
	assign col_int   = col_trunc[37:24];
	assign row_int   = row_trunc[37:24];
	assign col_ok    = !col_int[13] && (col_int[12:0] < 13'(FRAME_WIDTH));
	assign row_ok    = !row_int[13] && (row_int[12:0] < 13'(FRAME_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= 32'sd16777216;
			y_q <= 32'sd8388608;
			z_q <= 32'sd1677722;
		end else begin
			case (cmd.op)
				OP_UPD_X: x_q <= x_new;
				OP_UPD_Y: y_q <= y_new;
				OP_UPD_Z: z_q <= z_new;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_DIFF_YX:     acc_q <= diff_yx;
			OP_UPD_X:       acc_q <= diff_rz;
			OP_SUB_Y:       acc_q <= diff_py;
			OP_MUL_BETA:    acc_q <= qprod;
			OP_SUB_PROD:    acc_q <= diff_ap;
			default: begin
			end
		endcase
		case (cmd.op)
			OP_MUL_SIGMA, OP_MUL_DT_PROD, OP_MUL_X_ACC, OP_MUL_DT_ACC,
			OP_MUL_XY, OP_MUL_BETA: begin
				prod_q <= mul_p;
			end
			default: begin
			end
		endcase
	end

	// The x and y states are final once the z update runs.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_UPD_Z) begin
			col_q      <= col_int[PIX_W-1:0];
			row_q      <= row_int[PIX_W-1:0];
			in_frame_q <= col_ok && row_ok;
		end
	end

	assign x_value      = x_q;
	assign y_value      = y_q;
	assign z_value      = z_q;
	assign pixel_column = col_q;
	assign pixel_row    = row_q;
	assign in_frame     = in_frame_q;

endmodule

`default_nettype wire

/* rtl/lorenz_euler_step.sv */
// ----------------------------------------------------------------------------
// Lorenz Euler step
// One forward-Euler step of the Lorenz system in Q8.24 per request, with the
// x-y projection pixel of the new state.
// ----------------------------------------------------------------------------
//  Channel   Handshake                 Payload
//  request   tick_valid / tick_stall   tick
//  result    res_valid / res_stall     x_value y_value z_value pixel_column
//                                      pixel_row in_frame
//  config    cfg_write                 cfg_index cfg_data
//
// The result turns valid after a request with tick set is taken and the controller
// has run the x, y and z update states in order; the products of each update
// share one 32x32 multiplier, so they run one after another.
// A request with tick clear is taken and gives no result.
// The next request is taken in the cycle after the result is taken.
// Reset loads the default coefficients and the initial state.
// ----------------------------------------------------------------------------
`default_nettype none

module lorenz_euler_step
	import les_pkg::*;
#(
	parameter int FRAME_WIDTH  = 1000,
	parameter int FRAME_HEIGHT = 800
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_write,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                    tick_valid,
	output logic                         tick_stall,
	input  wire logic                    tick,
	output logic                         res_valid,
	input  wire logic                    res_stall,
	output logic signed [31:0]           x_value,
	output logic signed [31:0]           y_value,
	output logic signed [31:0]           z_value,
	output logic signed [PIX_W-1:0]      pixel_column,
	output logic signed [PIX_W-1:0]      pixel_row,
	output logic                         in_frame
);

	les_cmd_t cmd;

	les_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_stall (tick_stall),
		.tick       (tick),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.cmd        (cmd)
	);

	les_dp #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.x_value      (x_value),
		.y_value      (y_value),
		.z_value      (z_value),
		.pixel_column (pixel_column),
		.pixel_row    (pixel_row),
		.in_frame     (in_frame)
	);

endmodule

`default_nettype wire

/* rtl/les_checker.sv */
// ----------------------------------------------------------------------------
// Lorenz Euler step checker
// Port-level assertions on request and result ordering, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module les_checker
	import les_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               tick_valid,
	input wire logic               tick_stall,
	input wire logic               tick,
	input wire logic               res_valid,
	input wire logic               res_stall,
	input wire logic signed [31:0] x_value,
	input wire logic signed [31:0] z_value
);

	// A held result keeps its x and z state values.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(x_value) && $stable(z_value))
		else $error("result changed while stalled");

	// No request is taken while a result is pending.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> tick_stall)
		else $error("request taken while result pending");

	// A taken result is delivered once.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall |=> !res_valid)
		else $error("result repeated");

	// A step request keeps the block busy and gives no result at once.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && !tick_stall && tick |=> tick_stall && !res_valid)
		else $error("step request not held busy");

	// An empty request produces no result and leaves the block free.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && !tick_stall && !tick |=> !res_valid && !tick_stall)
		else $error("empty request produced a result");

endmodule

bind lorenz_euler_step les_checker u_les_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.tick_valid (tick_valid),
	.tick_stall (tick_stall),
	.tick       (tick),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.x_value    (x_value),
	.z_value    (z_value)
);

`default_nettype wire
